/* sv/bst_pkg.sv */
// Shared types and constants for the bounded sequence table.
package bst_pkg;

    localparam logic [2:0] CMD_INSERT_AT     = 3'd0;
    localparam logic [2:0] CMD_INSERT_SORTED = 3'd1;
    localparam logic [2:0] CMD_ERASE_AT      = 3'd2;
    localparam logic [2:0] CMD_REMOVE_MATCH  = 3'd3;
    localparam logic [2:0] CMD_READ_AT       = 3'd4;
    localparam logic [2:0] CMD_WRITE_AT      = 3'd5;
    localparam logic [2:0] CMD_FIND_FIRST    = 3'd6;

    localparam int CFG_WIDTH = 9;
    localparam logic [CFG_WIDTH-1:0] MAX_ITEMS_RESET = 9'd256;
    localparam logic [0:0] REG_MAX_ITEMS = 1'b0;

    // Operation broadcast from the controller to every cell.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN,
        OP_WRITE,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     sel;
    } cell_ctl_t;

endpackage

/* sv/bst_cell.sv */
// One storage cell of the table: holds an entry and trades it with its neighbors.
module bst_cell
    import bst_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  cell_op_t               op,
    input  logic                   sel,
    input  logic                   up_en,
    input  logic                   down_en,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    input  logic [VALUE_WIDTH-1:0] next_value,
    input  logic [VALUE_WIDTH-1:0] wr_value,
    output logic [VALUE_WIDTH-1:0] value
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (op)
            OP_SHIFT_UP:
            begin
                if (sel)
                    value_next = wr_value;
                else if (up_en)
                    value_next = prev_value;
            end
            OP_SHIFT_DOWN:
            begin
                if (down_en)
                    value_next = next_value;
            end
            OP_WRITE:
            begin
                if (sel)
                    value_next = wr_value;
            end
            OP_ROTATE:
            begin
                // Advance cells below the tail, load the tail, hold the rest.
                if (sel)
                    value_next = wr_value;
                else if (!up_en)
                    value_next = next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* sv/bst_ctrl.sv */
// Command sequencer: scans, rotates and shifts the cell chain.
module bst_ctrl
    import bst_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int PW          = 9
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2:0]             cmd,
    input  logic [PW-1:0]          position,
    input  logic [VALUE_WIDTH-1:0] value_in,
    input  logic [CFG_WIDTH-1:0]   max_items,
    input  logic [VALUE_WIDTH-1:0] head_value,
    input  logic [VALUE_WIDTH-1:0] pos_value,
    output logic                   busy,
    output cell_ctl_t              ctl,
    output logic [PW-1:0]          ctl_pos,
    output logic [VALUE_WIDTH-1:0] ctl_value,
    output logic                   done,
    output logic                   ok,
    output logic [7:0]             index,
    output logic [31:0]            read_value,
    output logic [8:0]             removed_count,
    output logic [8:0]             count,
    output logic                   is_empty
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_REMOVE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [PW-1:0] CAP = PW'(CAPACITY);

    logic [2:0]             state_reg, state_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [PW-1:0]          count_reg, count_next;
    logic [PW-1:0]          iter_reg, iter_next;
    logic [PW-1:0]          kept_reg, kept_next;
    logic                   found_reg, found_next;
    logic [PW-1:0]          hit_reg, hit_next;
    logic                   ok_reg, ok_next;
    logic [7:0]             idx_reg, idx_next;
    logic [31:0]            rd_reg, rd_next;
    logic [8:0]             rem_reg, rem_next;
    logic                   done_reg, done_next;
    logic [PW-1:0]          limit;
    logic                   can_insert;

    always_comb
    begin
        if (PW'(max_items) > CAP)
            limit = CAP;
        else
            limit = PW'(max_items);
        can_insert = (count_reg < limit) && (count_reg < CAP);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        count_next = count_reg;
        iter_next  = iter_reg;
        kept_next  = kept_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        ok_next    = ok_reg;
        idx_next   = idx_reg;
        rd_next    = rd_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        ctl.op     = OP_HOLD;
        ctl.sel    = 1'b0;
        ctl_pos    = pos_reg;
        ctl_value  = val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    pos_next   = position;
                    val_next   = value_in;
                    iter_next  = '0;
                    kept_next  = count_reg;
                    found_next = 1'b0;
                    hit_next   = count_reg;
                    ok_next    = 1'b0;
                    idx_next   = '0;
                    rd_next    = '0;
                    rem_next   = '0;
                    case (cmd)
                        CMD_INSERT_SORTED, CMD_FIND_FIRST:
                            state_next = (count_reg == '0) ? ST_APPLY : ST_SCAN;
                        CMD_REMOVE_MATCH:
                            state_next = (count_reg == '0) ? ST_DONE : ST_REMOVE;
                        default:
                            state_next = ST_APPLY;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Rotate the live entries once, checking the head cell each step.
                ctl.op    = OP_ROTATE;
                ctl_pos   = count_reg - 1'b1;
                ctl_value = head_value;
                iter_next = iter_reg + 1'b1;
                if (!found_reg)
                begin
                    if (cmd_reg == CMD_FIND_FIRST ? head_value == val_reg
                                                  : val_reg <= head_value)
                    begin
                        found_next = 1'b1;
                        hit_next   = iter_reg;
                    end
                end
                if (iter_reg == count_reg - 1'b1)
                    state_next = ST_APPLY;
            end
            ST_REMOVE:
            begin
                // Rotate the live entries through the head; drop a match off the tail.
                ctl.op    = OP_ROTATE;
                ctl_pos   = kept_reg - 1'b1;
                ctl_value = head_value;
                iter_next = iter_reg + 1'b1;
                if (head_value == val_reg)
                begin
                    rem_next  = rem_reg + 1'b1;
                    kept_next = kept_reg - 1'b1;
                end
                if (iter_reg == count_reg - 1'b1)
                begin
                    count_next = kept_next;
                    state_next = ST_DONE;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_INSERT_AT:
                    begin
                        if (can_insert && pos_reg <= count_reg)
                        begin
                            ctl.op     = OP_SHIFT_UP;
                            count_next = count_reg + 1'b1;
                            ok_next    = 1'b1;
                        end
                    end
                    CMD_INSERT_SORTED:
                    begin
                        ctl_pos = hit_reg;
                        if (can_insert)
                        begin
                            ctl.op     = OP_SHIFT_UP;
                            count_next = count_reg + 1'b1;
                            ok_next    = 1'b1;
                            idx_next   = hit_reg[7:0];
                        end
                    end
                    CMD_ERASE_AT:
                    begin
                        if (pos_reg < count_reg)
                        begin
                            ctl.op     = OP_SHIFT_DOWN;
                            count_next = count_reg - 1'b1;
                            ok_next    = 1'b1;
                        end
                    end
                    CMD_READ_AT:
                    begin
                        if (pos_reg < count_reg)
                        begin
                            ok_next = 1'b1;
                            rd_next = 32'(pos_value);
                        end
                    end
                    CMD_WRITE_AT:
                    begin
                        if (pos_reg < count_reg)
                        begin
                            ctl.op  = OP_WRITE;
                            ok_next = 1'b1;
                        end
                    end
                    CMD_FIND_FIRST:
                    begin
                        if (found_reg)
                        begin
                            ok_next  = 1'b1;
                            idx_next = hit_reg[7:0];
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (cmd_reg == CMD_REMOVE_MATCH)
                    ok_next = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        iter_reg  <= iter_next;
        kept_reg  <= kept_next;
        found_reg <= found_next;
        hit_reg   <= hit_next;
        ok_reg    <= ok_next;
        idx_reg   <= idx_next;
        rd_reg    <= rd_next;
        rem_reg   <= rem_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign ok            = ok_reg;
    assign index         = idx_reg;
    assign read_value    = rd_reg;
    assign removed_count = rem_reg;
    assign count         = 9'(count_reg);
    assign is_empty      = (count_reg == '0);

endmodule

/* sv/bounded_sequence_table.sv */
// Top level of the bounded sequence table: APB register, sequencer and cell chain.
//
// Commands: pulse start with cmd, position and item_value while busy is low;
// the transaction is accepted on that edge and busy rises the next cycle.
// Exactly one result follows on the result ports, marked by a single-cycle
// done; the receiver cannot stall it. busy is already low in the done cycle.
// Read, write, positional insert, erase and the unused command pass through the
// apply and done states; a new command is taken only once busy is low again.
// Sorted insert and find rotate the live entries once through the head cell,
// one entry per cycle, in the scan state, then apply and done; remove does the
// same lap in the remove state, then done. The entry count sets the lap length.
// The APB port holds max_items at byte address 0; pready is always high.
// Write it only while busy is low and no result is pending.
// Reset clears the count and restores max_items to 256; entry contents are
// undefined until written.
module bounded_sequence_table
    import bst_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [8:0]  position,
    input  logic [31:0] item_value,
    output logic        done,
    output logic        ok,
    output logic [7:0]  index,
    output logic [31:0] read_value,
    output logic [8:0]  removed_count,
    output logic [8:0]  count,
    output logic        is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = ($clog2(CAPACITY + 1) > 9) ? $clog2(CAPACITY + 1) : 9;

    logic [CFG_WIDTH-1:0]   max_items_reg;
    cell_ctl_t              ctl;
    logic [PW-1:0]          ctl_pos;
    logic [VALUE_WIDTH-1:0] ctl_value;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] value_in;
    logic [VALUE_WIDTH-1:0] pos_value;
    logic [PW-1:0]          pos_ext;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_items_reg <= MAX_ITEMS_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_MAX_ITEMS)
            max_items_reg <= pwdata[CFG_WIDTH-1:0];
    end

    assign prdata = (paddr[2] == REG_MAX_ITEMS) ? 32'(max_items_reg) : '0;

    assign value_in  = VALUE_WIDTH'(item_value);
    assign pos_value = (PW'(ctl_pos) < PW'(CAPACITY)) ? cell_value[ctl_pos[AW-1:0]] : '0;
    assign pos_ext   = ctl_pos;

    bst_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .PW          (PW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .position      (PW'(position)),
        .value_in      (value_in),
        .max_items     (max_items_reg),
        .head_value    (cell_value[0]),
        .pos_value     (pos_value),
        .busy          (busy),
        .ctl           (ctl),
        .ctl_pos       (ctl_pos),
        .ctl_value     (ctl_value),
        .done          (done),
        .ok            (ok),
        .index         (index),
        .read_value    (read_value),
        .removed_count (removed_count),
        .count         (count),
        .is_empty      (is_empty)
    );

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] prev_v;
            logic [VALUE_WIDTH-1:0] next_v;
            if (g == 0)
            begin : g_first
                assign prev_v = cell_value[0];
            end
            else
            begin : g_mid
                assign prev_v = cell_value[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign next_v = cell_value[0];
            end
            else
            begin : g_inner
                assign next_v = cell_value[g+1];
            end
            bst_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .op         (ctl.op),
                .sel        (pos_ext == PW'(g)),
                .up_en      (PW'(g) > pos_ext),
                .down_en    (PW'(g) >= pos_ext),
                .prev_value (prev_v),
                .next_value (next_v),
                .wr_value   (ctl_value),
                .value      (cell_value[g])
            );
        end
    endgenerate

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bounded sequence table: directed rows, then random commands.
module testbench;
    import bst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        ok;
        logic [7:0]  index;
        logic [31:0] read_value;
        logic [8:0]  removed_count;
        logic [8:0]  count;
        logic        is_empty;
    } outcome_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [8:0]  position;
        logic [31:0] item_value;
        logic        typed;
        outcome_t    want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  cmd = '0;
    logic [8:0]  position = '0;
    logic [31:0] item_value = '0;
    logic        done;
    logic        ok;
    logic [7:0]  index;
    logic [31:0] read_value;
    logic [8:0]  removed_count;
    logic [8:0]  count;
    logic        is_empty;

    logic [31:0] table_model [DEPTH];
    int unsigned list_len;
    int unsigned capacity_reg;
    outcome_t    pending_outcomes [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          result_count = 0;
    int          commands_sent = 0;
    int          ok_seen = 0;
    logic        quiet_tail = 1'b0;

    bounded_sequence_table u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'd0);
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (ok)
                    ok_seen++;
                if (ok !== exp_o.ok)
                    report_mismatch("ok", 32'(ok), 32'(exp_o.ok));
                if (index !== exp_o.index)
                    report_mismatch("index", 32'(index), 32'(exp_o.index));
                if (read_value !== exp_o.read_value)
                    report_mismatch("read_value", read_value, exp_o.read_value);
                if (removed_count !== exp_o.removed_count)
                    report_mismatch("removed_count", 32'(removed_count),
                                    32'(exp_o.removed_count));
                if (count !== exp_o.count)
                    report_mismatch("count", 32'(count), 32'(exp_o.count));
                if (is_empty !== exp_o.is_empty)
                    report_mismatch("is_empty", 32'(is_empty), 32'(exp_o.is_empty));
            end
        end
    end

    function automatic logic place_entry(int unsigned slot, logic [31:0] v);
        int unsigned lim;
        lim = capacity_reg > DEPTH ? DEPTH : capacity_reg;
        if (list_len >= lim || slot > list_len)
            return 1'b0;
        for (int i = list_len; i > slot; i--)
            table_model[i] = table_model[i-1];
        table_model[slot] = v;
        list_len++;
        return 1'b1;
    endfunction

    function automatic outcome_t table_outcome(logic [2:0] c, logic [8:0] p, logic [31:0] v);
        outcome_t o;
        int unsigned i;
        int unsigned w;
        o = '0;
        case (c)
            CMD_INSERT_AT:
                o.ok = place_entry(p, v);
            CMD_INSERT_SORTED:
            begin
                for (i = 0; i < list_len; i++)
                    if (v <= table_model[i])
                        break;
                if (place_entry(i, v))
                begin
                    o.ok = 1'b1;
                    o.index = i[7:0];
                end
            end
            CMD_ERASE_AT:
                if (p < list_len)
                begin
                    for (i = p; i + 1 < list_len; i++)
                        table_model[i] = table_model[i+1];
                    list_len--;
                    o.ok = 1'b1;
                end
            CMD_REMOVE_MATCH:
            begin
                w = 0;
                for (i = 0; i < list_len; i++)
                    if (table_model[i] != v)
                        table_model[w++] = table_model[i];
                o.removed_count = 9'(list_len - w);
                list_len = w;
                o.ok = 1'b1;
            end
            CMD_READ_AT:
                if (p < list_len)
                begin
                    o.read_value = table_model[p];
                    o.ok = 1'b1;
                end
            CMD_WRITE_AT:
                if (p < list_len)
                begin
                    table_model[p] = v;
                    o.ok = 1'b1;
                end
            CMD_FIND_FIRST:
                for (i = 0; i < list_len; i++)
                    if (table_model[i] == v)
                    begin
                        o.ok = 1'b1;
                        o.index = i[7:0];
                        break;
                    end
            default: ;
        endcase
        o.count = 9'(list_len);
        o.is_empty = (list_len == 0);
        return o;
    endfunction

    task automatic idle_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(posedge clk);
    endtask

    task automatic issue_command(logic [2:0] c, logic [8:0] p, logic [31:0] v,
                                 logic typed, outcome_t want);
        outcome_t o;
        idle_gap();
        start <= 1'b1;
        cmd <= c;
        position <= p;
        item_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        o = table_outcome(c, p, v);
        if (typed && o !== want)
            report_mismatch("table row vs predictor", 32'(o), 32'(want));
        pending_outcomes.push_back(o);
        commands_sent++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
    endtask

    task automatic set_capacity(int unsigned n);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_ITEMS, 2'b00};
        pwdata <= 32'(n);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        capacity_reg = n & 9'h1FF;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            2: return $urandom;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    task automatic random_phase(int n, int unsigned pos_span);
        logic [2:0] c;
        logic [8:0] p;
        for (int k = 0; k < n; k++)
        begin
            c = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 2) != 0 && list_len < 8)
                c = $urandom_range(0, 1) ? CMD_INSERT_SORTED : CMD_INSERT_AT;
            if ($urandom_range(0, 19) == 0)
                p = 9'($urandom);
            else
                p = 9'($urandom_range(0, list_len + pos_span));
            issue_command(c, p, pick_value(), 1'b0, '0);
        end
    endtask

    row_t directed [$];

    function automatic outcome_t res(logic k, logic [7:0] ix, logic [31:0] rd,
                                     logic [8:0] rm, logic [8:0] n);
        return '{k, ix, rd, rm, n, n == 0};
    endfunction

    initial
    begin
        list_len = 0;
        capacity_reg = MAX_ITEMS_RESET;
        directed = '{
            '{CMD_READ_AT,       9'd0,   32'h0,         1'b1, res(0, 0, 0, 0, 0)},
            '{CMD_ERASE_AT,      9'd0,   32'h0,         1'b1, res(0, 0, 0, 0, 0)},
            '{CMD_WRITE_AT,      9'd0,   32'h5,         1'b1, res(0, 0, 0, 0, 0)},
            '{CMD_FIND_FIRST,    9'd0,   32'h5,         1'b1, res(0, 0, 0, 0, 0)},
            '{CMD_REMOVE_MATCH,  9'd0,   32'h5,         1'b1, res(1, 0, 0, 0, 0)},
            '{3'd7,              9'd0,   32'h5,         1'b1, res(0, 0, 0, 0, 0)},
            '{CMD_INSERT_AT,     9'd1,   32'h1,         1'b1, res(0, 0, 0, 0, 0)},
            '{CMD_INSERT_AT,     9'd0,   32'hFFFF_FFFF, 1'b1, res(1, 0, 0, 0, 1)},
            '{CMD_INSERT_SORTED, 9'd0,   32'h0,         1'b1, res(1, 0, 0, 0, 2)},
            '{CMD_INSERT_SORTED, 9'd0,   32'h7,         1'b0, '0},
            '{CMD_INSERT_AT,     9'd511, 32'h7,         1'b0, '0},
            '{CMD_INSERT_AT,     9'd3,   32'h7,         1'b0, '0},
            '{CMD_INSERT_SORTED, 9'd0,   32'hFFFF_FFFF, 1'b0, '0},
            '{CMD_READ_AT,       9'd4,   32'h0,         1'b0, '0},
            '{CMD_READ_AT,       9'd256, 32'h0,         1'b0, '0},
            '{CMD_FIND_FIRST,    9'd0,   32'h7,         1'b0, '0},
            '{CMD_WRITE_AT,      9'd1,   32'hA5A5_5A5A, 1'b0, '0},
            '{CMD_REMOVE_MATCH,  9'd0,   32'h7,         1'b0, '0},
            '{CMD_ERASE_AT,      9'd0,   32'h0,         1'b0, '0},
            '{CMD_ERASE_AT,      9'd9,   32'h0,         1'b0, '0},
            '{CMD_READ_AT,       9'd0,   32'h0,         1'b0, '0}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[r])
            issue_command(directed[r].cmd, directed[r].position, directed[r].item_value,
                          directed[r].typed, directed[r].want);
        set_capacity(1);
        issue_command(CMD_INSERT_AT, 9'd0, 32'h3, 1'b0, '0);
        set_capacity(0);
        issue_command(CMD_INSERT_SORTED, 9'd0, 32'h3, 1'b0, '0);
        random_phase(40, 3);
        set_capacity(300);
        // raise max_items past the default and fill the list to full capacity
        while (list_len < DEPTH)
            issue_command(CMD_INSERT_AT, 9'($urandom_range(0, list_len)), pick_value(),
                          1'b0, '0);
        random_phase(30, 3);
        set_capacity(5);
        random_phase(150, 3);
        set_capacity(16);
        random_phase(160, 3);
        set_capacity(256);
        random_phase(350, 6);
        set_capacity($urandom_range(1, 40));
        random_phase(200, 3);
        quiet_tail = 1'b1;
        random_phase(150, 3);
        drain();
        $display("%0d commands issued, %0d results checked, %0d succeeded",
                 commands_sent, result_count, ok_seen);
        $display("capacities covered: 0, 1, 5, 16, 256, 300 and a random one");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
